// File: rtl/pra_pkg.sv
`default_nettype none
package pra_pkg;

    localparam int POS_W    = 24;
    localparam int DIFF_W   = POS_W + 1;
    localparam int SEP_W    = 43;
    localparam int DXY_W    = 31;
    localparam int DIST_W   = 30;
    localparam int WGT_W    = 24;
    localparam int FORCE_W  = 32;
    localparam int ALU_W    = 64;
    localparam int ITER_W   = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int HOR_REGS = 4;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_RADIUS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROWTH      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HCOUNT      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOR0        = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOR1        = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOR2        = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOR3        = 8'd7;

    // iteration counts of the shared unit
    localparam logic [ITER_W-1:0] IT_VEL   = 7'd16;
    localparam logic [ITER_W-1:0] IT_SQ    = 7'd31;
    localparam logic [ITER_W-1:0] IT_SQRT  = 7'd31;
    localparam logic [ITER_W-1:0] IT_TG    = 7'd16;
    localparam logic [ITER_W-1:0] IT_COMB  = 7'd20;
    localparam logic [ITER_W-1:0] IT_W     = 7'd36;
    localparam logic [ITER_W-1:0] IT_MULW  = 7'd24;
    localparam logic [ITER_W-1:0] IT_DIV54 = 7'd54;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic                start;
        alu_op_t             op;
        logic [ALU_W-1:0]    a;
        logic [ALU_W-1:0]    b;
        logic [ITER_W-1:0]   iters;
    } alu_req_t;

    typedef struct packed {
        logic             done;
        logic [ALU_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        ST_VX, ST_VY, ST_SQX, ST_SQY, ST_SQRT, ST_TG, ST_COMB,
        ST_W, ST_P, ST_S, ST_CX, ST_DCX, ST_CY, ST_DCY
    } step_t;

    // separation at q.20 rounded to q.8, halves toward plus infinity
    function automatic logic signed [DXY_W-1:0] round_sep(
        input logic signed [DIFF_W-1:0] dp,
        input logic                     neg,
        input logic [SEP_W-1:0]         prod
    );
        logic signed [SEP_W-1:0] base;
        logic signed [SEP_W-1:0] sum;
        base = {{(SEP_W-DIFF_W-12){dp[DIFF_W-1]}}, dp, 12'b0};
        sum  = neg ? base - $signed(prod) : base + $signed(prod);
        sum  = sum + SEP_W'(2048);
        return DXY_W'(sum >>> 12);
    endfunction

    function automatic logic [DXY_W-1:0] mag_dxy(input logic signed [DXY_W-1:0] v);
        return v[DXY_W-1] ? DXY_W'(-v) : DXY_W'(v);
    endfunction

endpackage
`default_nettype wire

// File: rtl/pra_alu.sv
`default_nettype none
module pra_alu (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pra_pkg::alu_req_t req,
    output pra_pkg::alu_rsp_t      rsp
);
    import pra_pkg::*;

    alu_op_t           op_reg, op_next;
    logic [ALU_W-1:0]  x_reg, x_next;   // accumulator or remainder
    logic [ALU_W-1:0]  y_reg, y_next;   // multiplicand, divisor or root
    logic [ALU_W-1:0]  z_reg, z_next;   // multiplier, quotient or radicand
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb begin
        logic [ALU_W-1:0] rs;
        logic [ALU_W-1:0] tr;
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rs = '0;
        tr = '0;
        if (req.start) begin
            op_next   = req.op;
            cnt_next  = req.iters;
            busy_next = 1'b1;
            x_next    = '0;
            unique case (req.op)
                ALU_MUL: begin
                    y_next = req.a;
                    z_next = req.b;
                end
                ALU_DIV: begin
                    y_next = req.b;
                    z_next = req.a << (7'd64 - req.iters);
                end
                default: begin
                    y_next = '0;
                    z_next = req.a << (7'd64 - {req.iters[ITER_W-2:0], 1'b0});
                end
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                ALU_MUL: begin
                    if (z_reg[0]) x_next = x_reg + y_reg;
                    y_next = {y_reg[ALU_W-2:0], 1'b0};
                    z_next = {1'b0, z_reg[ALU_W-1:1]};
                end
                ALU_DIV: begin
                    rs = {x_reg[ALU_W-2:0], z_reg[ALU_W-1]};
                    if (rs >= y_reg) begin
                        x_next = rs - y_reg;
                        z_next = {z_reg[ALU_W-2:0], 1'b1};
                    end else begin
                        x_next = rs;
                        z_next = {z_reg[ALU_W-2:0], 1'b0};
                    end
                end
                default: begin
                    rs = {x_reg[ALU_W-3:0], z_reg[ALU_W-1:ALU_W-2]};
                    tr = {y_reg[ALU_W-3:0], 2'b01};
                    if (rs >= tr) begin
                        x_next = rs - tr;
                        y_next = {y_reg[ALU_W-2:0], 1'b1};
                    end else begin
                        x_next = rs;
                        y_next = {y_reg[ALU_W-2:0], 1'b0};
                    end
                    z_next = {z_reg[ALU_W-3:0], 2'b00};
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    always_comb begin
        rsp.done = done_reg;
        case (op_reg)
            ALU_MUL: rsp.result = x_reg;
            ALU_DIV: rsp.result = z_reg;
            default: rsp.result = y_reg;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/predictive_repulsion_accumulator.sv
`default_nettype none
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  tdata: 8 x 24 bit positions and velocities,
//                                           tuser: is_own, tlast: last_peer
// m_        out        m_tvalid / m_tready  tdata: force_x, force_y
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one shared bit-serial unit (multiply, restoring divide, square root) runs every step;
// each operation is issued in S_ISSUE and its result taken in S_WAIT;
// a horizon inside the zone runs 14 operations, one outside the zone or too close stops after 7;
// an item goes from S_IDLE through its horizons to S_EMIT, a self item straight to S_EMIT
// reset is synchronous, active low; it loads the register defaults and clears the sums
// s_tready is low while an item is at work and while a result waits for a free output
// register; config writes are taken in every cycle
module predictive_repulsion_accumulator #(
    parameter int MAX_HORIZONS = 4,
    parameter int MIN_DIST     = 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // own_pos_x, own_pos_y, own_vel_x, own_vel_y, peer_pos_x, peer_pos_y, peer_vel_x, peer_vel_y
    input  wire logic [191:0]                      s_tdata,
    // is_own
    input  wire logic                              s_tuser,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // force_x, force_y
    output logic [63:0]                            m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pra_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import pra_pkg::*;

    localparam int HLIM = (MAX_HORIZONS < HOR_REGS) ? MAX_HORIZONS : HOR_REGS;

    // configuration
    logic [19:0] zone_radius_reg;
    logic [15:0] gain_reg;
    logic [15:0] growth_reg;
    logic [2:0]  hcount_reg;
    logic [15:0] horizon_reg [HOR_REGS];

    // sequencer and working registers
    state_t                    state_reg, state_next;
    step_t                     step_reg, step_next;
    logic [2:0]                hcnt_reg, hcnt_next;
    logic                      last_reg, last_next;
    logic signed [DIFF_W-1:0]  dpx_reg, dpx_next, dpy_reg, dpy_next;
    logic signed [DIFF_W-1:0]  dvx_reg, dvx_next, dvy_reg, dvy_next;
    logic signed [DXY_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic [DIST_W-1:0]         d_reg, d_next, comb_reg, comb_next;
    logic [WGT_W-1:0]          w_reg, w_next, s_reg, s_next;
    logic [ALU_W-1:0]          tmp_reg, tmp_next;
    logic signed [FORCE_W-1:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [63:0]               m_tdata_reg, m_tdata_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic [2:0]        hor_used;
    logic [15:0]       t_cur;
    logic [DXY_W-1:0]  ax, ay;
    logic [DIFF_W-1:0] avx, avy;
    logic [DIST_W-1:0] comb_new;
    logic [DIST_W-1:0] gap;

    function automatic logic signed [FORCE_W-1:0] sat_add(
        input logic signed [FORCE_W-1:0] acc,
        input logic [ALU_W-1:0]          mag,
        input logic                      neg
    );
        logic signed [FORCE_W:0] c;
        logic signed [FORCE_W:0] s;
        c = neg ? -$signed({1'b0, mag[FORCE_W-1:0]}) : $signed({1'b0, mag[FORCE_W-1:0]});
        s = {acc[FORCE_W-1], acc} + c;
        if (s[FORCE_W] != s[FORCE_W-1])
            return s[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
        return s[FORCE_W-1:0];
    endfunction

    pra_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    assign hor_used  = (hcount_reg > 3'(HLIM)) ? 3'(HLIM) : hcount_reg;
    assign t_cur     = horizon_reg[hcnt_reg[1:0]];
    assign ax        = mag_dxy(dx_reg);
    assign ay        = mag_dxy(dy_reg);
    assign avx       = dvx_reg[DIFF_W-1] ? DIFF_W'(-dvx_reg) : DIFF_W'(dvx_reg);
    assign avy       = dvy_reg[DIFF_W-1] ? DIFF_W'(-dvy_reg) : DIFF_W'(dvy_reg);
    assign comb_new  = alu_rsp.result[52:23];
    assign gap       = comb_reg - d_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // operand selection for the shared unit
    always_comb begin
        alu_req.start = (state_reg == S_ISSUE);
        alu_req.op    = ALU_MUL;
        alu_req.a     = '0;
        alu_req.b     = '0;
        alu_req.iters = IT_VEL;
        unique case (step_reg)
            ST_VX: begin
                alu_req.a = ALU_W'(avx);
                alu_req.b = ALU_W'(t_cur);
            end
            ST_VY: begin
                alu_req.a = ALU_W'(avy);
                alu_req.b = ALU_W'(t_cur);
            end
            ST_SQX: begin
                alu_req.a     = ALU_W'(ax);
                alu_req.b     = ALU_W'(ax);
                alu_req.iters = IT_SQ;
            end
            ST_SQY: begin
                alu_req.a     = ALU_W'(ay);
                alu_req.b     = ALU_W'(ay);
                alu_req.iters = IT_SQ;
            end
            ST_SQRT: begin
                alu_req.op    = ALU_SQRT;
                alu_req.a     = tmp_reg;
                alu_req.iters = IT_SQRT;
            end
            ST_TG: begin
                alu_req.a     = ALU_W'(growth_reg);
                alu_req.b     = ALU_W'(t_cur);
                alu_req.iters = IT_TG;
            end
            ST_COMB: begin
                alu_req.a     = tmp_reg + (ALU_W'(1) << 24);
                alu_req.b     = ALU_W'(zone_radius_reg);
                alu_req.iters = IT_COMB;
            end
            ST_W: begin
                alu_req.op    = ALU_DIV;
                alu_req.a     = ALU_W'(gain_reg) << 20;
                alu_req.b     = ALU_W'(t_cur) + ALU_W'(4096);
                alu_req.iters = IT_W;
            end
            ST_P: begin
                alu_req.a     = ALU_W'(gap);
                alu_req.b     = ALU_W'(w_reg);
                alu_req.iters = IT_MULW;
            end
            ST_S: begin
                alu_req.op    = ALU_DIV;
                alu_req.a     = tmp_reg;
                alu_req.b     = ALU_W'(comb_reg);
                alu_req.iters = IT_DIV54;
            end
            ST_CX: begin
                alu_req.a     = ALU_W'(ax);
                alu_req.b     = ALU_W'(s_reg);
                alu_req.iters = IT_MULW;
            end
            ST_CY: begin
                alu_req.a     = ALU_W'(ay);
                alu_req.b     = ALU_W'(s_reg);
                alu_req.iters = IT_MULW;
            end
            ST_DCX, ST_DCY: begin
                alu_req.op    = ALU_DIV;
                alu_req.a     = tmp_reg;
                alu_req.b     = ALU_W'(d_reg);
                alu_req.iters = IT_DIV54;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        logic advance;
        advance       = 1'b0;
        state_next    = state_reg;
        step_next     = step_reg;
        hcnt_next     = hcnt_reg;
        last_next     = last_reg;
        dpx_next      = dpx_reg;
        dpy_next      = dpy_reg;
        dvx_next      = dvx_reg;
        dvy_next      = dvy_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        d_next        = d_reg;
        comb_next     = comb_reg;
        w_next        = w_reg;
        s_next        = s_reg;
        tmp_next      = tmp_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    dpx_next  = DIFF_W'($signed(s_tdata[23:0]))   - DIFF_W'($signed(s_tdata[119:96]));
                    dpy_next  = DIFF_W'($signed(s_tdata[47:24]))  - DIFF_W'($signed(s_tdata[143:120]));
                    dvx_next  = DIFF_W'($signed(s_tdata[71:48]))  - DIFF_W'($signed(s_tdata[167:144]));
                    dvy_next  = DIFF_W'($signed(s_tdata[95:72]))  - DIFF_W'($signed(s_tdata[191:168]));
                    last_next = s_tlast;
                    hcnt_next = '0;
                    step_next = ST_VX;
                    if (s_tuser || hor_used == 3'd0)
                        state_next = S_EMIT;
                    else
                        state_next = S_ISSUE;
                end
            end
            S_ISSUE: state_next = S_WAIT;
            S_WAIT: begin
                if (alu_rsp.done) begin
                    state_next = S_ISSUE;
                    unique case (step_reg)
                        ST_VX: begin
                            dx_next   = round_sep(dpx_reg, dvx_reg[DIFF_W-1],
                                                  alu_rsp.result[SEP_W-1:0]);
                            step_next = ST_VY;
                        end
                        ST_VY: begin
                            dy_next   = round_sep(dpy_reg, dvy_reg[DIFF_W-1],
                                                  alu_rsp.result[SEP_W-1:0]);
                            step_next = ST_SQX;
                        end
                        ST_SQX: begin
                            tmp_next  = alu_rsp.result;
                            step_next = ST_SQY;
                        end
                        ST_SQY: begin
                            tmp_next  = tmp_reg + alu_rsp.result;
                            step_next = ST_SQRT;
                        end
                        ST_SQRT: begin
                            d_next    = alu_rsp.result[DIST_W-1:0];
                            step_next = ST_TG;
                        end
                        ST_TG: begin
                            tmp_next  = alu_rsp.result;
                            step_next = ST_COMB;
                        end
                        ST_COMB: begin
                            comb_next = comb_new;
                            // inside the zone and not too close
                            if (d_reg < comb_new && d_reg > DIST_W'(MIN_DIST))
                                step_next = ST_W;
                            else
                                advance = 1'b1;
                        end
                        ST_W: begin
                            w_next    = alu_rsp.result[WGT_W-1:0];
                            step_next = ST_P;
                        end
                        ST_P: begin
                            tmp_next  = alu_rsp.result;
                            step_next = ST_S;
                        end
                        ST_S: begin
                            s_next    = alu_rsp.result[WGT_W-1:0];
                            step_next = ST_CX;
                        end
                        ST_CX, ST_CY: begin
                            tmp_next  = alu_rsp.result;
                            step_next = (step_reg == ST_CX) ? ST_DCX : ST_DCY;
                        end
                        ST_DCX: begin
                            sum_x_next = sat_add(sum_x_reg, alu_rsp.result, dx_reg[DXY_W-1]);
                            step_next  = ST_CY;
                        end
                        ST_DCY: begin
                            sum_y_next = sat_add(sum_y_reg, alu_rsp.result, dy_reg[DXY_W-1]);
                            advance    = 1'b1;
                        end
                        default: ;
                    endcase
                    if (advance) begin
                        step_next = ST_VX;
                        if (hcnt_reg + 3'd1 < hor_used)
                            hcnt_next = hcnt_reg + 3'd1;
                        else
                            state_next = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {sum_y_reg, sum_x_reg};
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= ST_VX;
            hcnt_reg     <= '0;
            last_reg     <= 1'b0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            hcnt_reg     <= hcnt_next;
            last_reg     <= last_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        dpx_reg     <= dpx_next;
        dpy_reg     <= dpy_next;
        dvx_reg     <= dvx_next;
        dvy_reg     <= dvy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        d_reg       <= d_next;
        comb_reg    <= comb_next;
        w_reg       <= w_next;
        s_reg       <= s_next;
        tmp_reg     <= tmp_next;
        m_tdata_reg <= m_tdata_next;
    end

    // register file, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_radius_reg <= 20'd7680;
            gain_reg        <= 16'd256;
            growth_reg      <= 16'd2048;
            hcount_reg      <= 3'd4;
            horizon_reg[0]  <= 16'd2048;
            horizon_reg[1]  <= 16'd4096;
            horizon_reg[2]  <= 16'd6144;
            horizon_reg[3]  <= 16'd8192;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ZONE_RADIUS: zone_radius_reg <= cfg_data[19:0];
                REG_GAIN:        gain_reg        <= cfg_data[15:0];
                REG_GROWTH:      growth_reg      <= cfg_data[15:0];
                REG_HCOUNT:      hcount_reg      <= cfg_data[2:0];
                REG_HOR0:        horizon_reg[0]  <= cfg_data[15:0];
                REG_HOR1:        horizon_reg[1]  <= cfg_data[15:0];
                REG_HOR2:        horizon_reg[2]  <= cfg_data[15:0];
                REG_HOR3:        horizon_reg[3]  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pra_pkg::*;

    // block parameters as instantiated below
    localparam int HORIZONS_MAX = 4;
    localparam int NEAR_LIMIT   = 1;
    // indexes outside the register list, the block ignores them
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 8'd8;
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = 8'd255;
    // cycles an item may still be at work after the last result came
    localparam int SETTLE_CYCLES = 2500;
    // cycles without any transfer before the run is abandoned
    localparam int STALL_LIMIT   = 40000;

    typedef struct {
        logic signed [23:0] own_px, own_py, own_vx, own_vy;
        logic signed [23:0] peer_px, peer_py, peer_vx, peer_vy;
        bit                 is_own;
        bit                 last_peer;
    } pair_t;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } force_t;

    logic                  aclk;
    logic                  aresetn;
    logic [191:0]          s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;

    predictive_repulsion_accumulator #(
        .MAX_HORIZONS(HORIZONS_MAX),
        .MIN_DIST    (NEAR_LIMIT)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mirror of the register file and the running sums
    longint zone_r, gain_r, growth_r, count_r;
    longint horizon_r [4];
    int     acc_x, acc_y;

    force_t force_expected [$];
    int     error_count;
    int     pairs_sent;
    int     forces_seen;
    int     burst_left;
    bit     bursty;

    // ---------------------------------------------------------------- predictor

    function automatic longint floor_sqrt(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic int add_clamped(int a, longint b);
        longint s;
        s = longint'(a) + b;
        if (s > 64'sd2147483647) return 32'sh7fffffff;
        if (s < -64'sd2147483648) return 32'sh80000000;
        return int'(s);
    endfunction

    // component times s over d, truncated toward zero
    function automatic longint scale_toward_zero(longint c, longint s, longint d);
        longint mag;
        mag = ((c < 0) ? -c : c) * s / d;
        return (c < 0) ? -mag : mag;
    endfunction

    // adds the repulsion of one pair to the sums, returns 1 when a force is due
    function automatic bit accumulate_repulsion(pair_t p, output force_t f);
        longint dpx, dpy, dvx, dvy, t, dx, dy, ax, ay, d, comb, w, s;
        int     n;
        if (!p.is_own) begin
            dpx = longint'(p.own_px) - longint'(p.peer_px);
            dpy = longint'(p.own_py) - longint'(p.peer_py);
            dvx = longint'(p.own_vx) - longint'(p.peer_vx);
            dvy = longint'(p.own_vy) - longint'(p.peer_vy);
            n = int'(count_r);
            if (n > HORIZONS_MAX) n = HORIZONS_MAX;
            if (n > 4) n = 4;
            for (int h = 0; h < n; h++) begin
                t  = horizon_r[h];
                // q.20 separation rounded to q.8, floor of (v + half)
                dx = (dpx * 4096 + dvx * t + 2048) >>> 12;
                dy = (dpy * 4096 + dvy * t + 2048) >>> 12;
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                d  = floor_sqrt(ax * ax + ay * ay);
                comb = (zone_r * ((64'sd1 <<< 24) + t * growth_r)) >>> 23;
                if (d < comb && d > NEAR_LIMIT) begin
                    w = (gain_r <<< 20) / (4096 + t);
                    s = w * (comb - d) / comb;
                    acc_x = add_clamped(acc_x, scale_toward_zero(dx, s, d));
                    acc_y = add_clamped(acc_y, scale_toward_zero(dy, s, d));
                end
            end
        end
        f.fx = acc_x;
        f.fy = acc_y;
        if (p.last_peer) begin
            acc_x = 0;
            acc_y = 0;
        end
        return p.last_peer;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
                 $signed(want), $realtime);
    endtask

    int   stall_phase;
    int   stall_mode;
    force_t head;

    // receiver stalls in modes that change each time stall_phase wraps
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
            stall_mode  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                forces_seen++;
                if (force_expected.size() == 0) begin
                    error_count++;
                    $display("force transfer with nothing expected at %0t", $realtime);
                end else begin
                    head = force_expected.pop_front();
                    if (m_tdata[31:0] !== head.fx)
                        report_mismatch("force_x", m_tdata[31:0], head.fx);
                    if (m_tdata[63:32] !== head.fy)
                        report_mismatch("force_y", m_tdata[63:32], head.fy);
                end
            end
            stall_phase <= (stall_phase == 96) ? 0 : stall_phase + 1;
            if (stall_phase == 96) stall_mode <= $urandom_range(2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(1));
                default: m_tready <= ($urandom_range(7) == 0);
            endcase
        end
    end

    // watchdog on cycles without any transfer
    int idle_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL predictive_repulsion_accumulator");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        int wid;
        logic [31:0] data;
        case (idx)
            REG_ZONE_RADIUS: wid = 20;
            REG_HCOUNT:      wid = 3;
            REG_GAIN, REG_GROWTH, REG_HOR0, REG_HOR1, REG_HOR2, REG_HOR3: wid = 16;
            default:         wid = 0;
        endcase
        // junk above the register width must be dropped
        data = (wid == 0) ? $urandom : (32'(value) | ($urandom << wid));
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_ZONE_RADIUS: zone_r   = data & 32'hfffff;
            REG_GAIN:        gain_r   = data & 32'hffff;
            REG_GROWTH:      growth_r = data & 32'hffff;
            REG_HCOUNT:      count_r  = data & 32'h7;
            REG_HOR0:        horizon_r[0] = data & 32'hffff;
            REG_HOR1:        horizon_r[1] = data & 32'hffff;
            REG_HOR2:        horizon_r[2] = data & 32'hffff;
            REG_HOR3:        horizon_r[3] = data & 32'hffff;
            default: ;
        endcase
    endtask

    // one pair transfer; valid stays high into the next pair of a burst
    task automatic send_pair(pair_t p);
        force_t f;
        int     gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {p.peer_vy, p.peer_vx, p.peer_py, p.peer_px,
                     p.own_vy, p.own_vx, p.own_py, p.own_px};
        s_tuser  <= p.is_own;
        s_tlast  <= p.last_peer;
        do @(posedge aclk); while (!s_tready);
        pairs_sent++;
        if (accumulate_repulsion(p, f))
            force_expected.insert(force_expected.size(), f);
        if (bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 1);
                gap = $urandom_range(20, 1);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // wait for all forces, then for any pair still at work
    task automatic settle();
        s_tvalid <= 1'b0;
        while (force_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic pair_t make_pair(int spread, int vel_spread, bit own, bit last);
        pair_t p;
        p.own_px  = 24'($urandom);
        p.own_py  = 24'($urandom);
        p.own_vx  = 24'($urandom_range(2 * vel_spread) - vel_spread);
        p.own_vy  = 24'($urandom_range(2 * vel_spread) - vel_spread);
        p.peer_px = p.own_px - 24'($urandom_range(2 * spread) - spread);
        p.peer_py = p.own_py - 24'($urandom_range(2 * spread) - spread);
        p.peer_vx = 24'($urandom_range(2 * vel_spread) - vel_spread);
        p.peer_vy = 24'($urandom_range(2 * vel_spread) - vel_spread);
        p.is_own    = own;
        p.last_peer = last;
        return p;
    endfunction

    function automatic pair_t noise_pair(bit last);
        pair_t p;
        p.own_px = 24'($urandom);  p.own_py = 24'($urandom);
        p.own_vx = 24'($urandom);  p.own_vy = 24'($urandom);
        p.peer_px = 24'($urandom); p.peer_py = 24'($urandom);
        p.peer_vx = 24'($urandom); p.peer_vy = 24'($urandom);
        p.is_own    = ($urandom_range(9) == 0);
        p.last_peer = last;
        return p;
    endfunction

    // a list of peers ending in a last one, mostly close encounters
    task automatic send_peer_list(int len, int spread);
        pair_t p;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                p = noise_pair(i == len - 1);
            else
                p = make_pair(spread, 2048, $urandom_range(9) == 0, i == len - 1);
            send_pair(p);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_defaults();
        pair_t p;
        // identical robots: distance zero, too close to push
        p = make_pair(0, 0, 1'b0, 1'b0);
        p.peer_vx = p.own_vx; p.peer_vy = p.own_vy;
        send_pair(p);
        // close peer, then a self item that still emits
        send_pair(make_pair(4000, 512, 1'b0, 1'b0));
        send_pair(make_pair(4000, 512, 1'b1, 1'b1));
        // self item alone emits a zero force
        send_pair(make_pair(100, 0, 1'b1, 1'b1));
        // field extremes
        p.own_px = 24'h7fffff; p.own_py = 24'h800000;
        p.own_vx = 24'h7fffff; p.own_vy = 24'h800000;
        p.peer_px = 24'h800000; p.peer_py = 24'h7fffff;
        p.peer_vx = 24'h800000; p.peer_vy = 24'h7fffff;
        p.is_own = 1'b0; p.last_peer = 1'b1;
        send_pair(p);
        p.own_px = 24'h7fffff; p.peer_px = 24'h7ffff0;
        p.own_py = 24'h800000; p.peer_py = 24'h800010;
        p.own_vx = 0; p.own_vy = 0; p.peer_vx = 0; p.peer_vy = 0;
        send_pair(p);
        // just past and at the minimum distance
        p.own_px = 0; p.own_py = 0; p.peer_px = 2; p.peer_py = 0;
        p.last_peer = 1'b0;
        send_pair(p);
        p.peer_px = 1;
        p.last_peer = 1'b1;
        send_pair(p);
        settle();
    endtask

    task automatic test_zero_radius();
        write_reg(REG_ZONE_RADIUS, 0);
        send_pair(make_pair(200, 100, 1'b0, 1'b0));
        send_pair(make_pair(200, 100, 1'b0, 1'b1));
        settle();
    endtask

    task automatic test_horizon_count();
        write_reg(REG_ZONE_RADIUS, 7680);
        write_reg(REG_HCOUNT, 0);
        send_pair(make_pair(2000, 100, 1'b0, 1'b1));
        settle();
        // beyond the horizon limit, clipped to four
        write_reg(REG_HCOUNT, 7);
        write_reg(REG_PAST_END, 0);
        write_reg(REG_TOP, 0);
        send_pair(make_pair(3000, 300, 1'b0, 1'b0));
        send_pair(make_pair(3000, 300, 1'b0, 1'b1));
        settle();
        write_reg(REG_HCOUNT, 1);
        send_pair(make_pair(3000, 300, 1'b0, 1'b1));
        settle();
    endtask

    task automatic test_extremes();
        write_reg(REG_ZONE_RADIUS, 20'hfffff);
        write_reg(REG_GAIN, 16'hffff);
        write_reg(REG_GROWTH, 16'hffff);
        write_reg(REG_HCOUNT, 4);
        write_reg(REG_HOR0, 0);
        write_reg(REG_HOR1, 16'hffff);
        write_reg(REG_HOR2, 1);
        write_reg(REG_HOR3, 16'h8000);
        send_pair(make_pair(1000000, 100000, 1'b0, 1'b0));
        send_pair(noise_pair(1'b0));
        send_pair(make_pair(8000000, 8000000, 1'b0, 1'b1));
        settle();
    endtask

    // many close peers on one side at full gain drive the sums into the clamp
    task automatic test_saturation();
        pair_t p;
        write_reg(REG_ZONE_RADIUS, 20'hfffff);
        write_reg(REG_GAIN, 16'hffff);
        write_reg(REG_GROWTH, 0);
        write_reg(REG_HCOUNT, 4);
        for (int h = 0; h < 4; h++) write_reg(CFG_IDX_W'(REG_HOR0 + h), 0);
        for (int sgn = 0; sgn < 2; sgn++) begin
            for (int i = 0; i < 40; i++) begin
                p = make_pair(0, 0, 1'b0, i == 39);
                p.peer_px = p.own_px + (sgn ? 24'sd3000 : -24'sd3000);
                p.peer_py = p.own_py + (sgn ? 24'sd2000 : -24'sd2000);
                send_pair(p);
            end
        end
        settle();
    endtask

    task automatic test_random_phases();
        int spread;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_ZONE_RADIUS, (ph % 3 == 0) ? $urandom_range(20'hfffff)
                                                     : $urandom_range(20000, 256));
            write_reg(REG_GAIN, $urandom_range(16'hffff));
            write_reg(REG_GROWTH, $urandom_range(16'hffff));
            write_reg(REG_HCOUNT, (ph == 7) ? 4 : $urandom_range(3, 1));
            for (int h = 0; h < 4; h++)
                write_reg(CFG_IDX_W'(REG_HOR0 + h), $urandom_range(16'hffff));
            bursty = (ph % 4 != 1);
            spread = (zone_r < 4000) ? 8000 : int'(zone_r) * 4;
            if (spread > 4000000) spread = 4000000;
            for (int lst = 0; lst < 10; lst++) begin
                send_peer_list($urandom_range(8, 1), spread);
                // hold off until the sums are all back
                if (ph == 2 && lst == 4) begin
                    s_tvalid <= 1'b0;
                    while (force_expected.size() != 0) @(posedge aclk);
                end
            end
            settle();
        end
        bursty = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        zone_r = 7680; gain_r = 256; growth_r = 2048; count_r = 4;
        horizon_r[0] = 2048; horizon_r[1] = 4096;
        horizon_r[2] = 6144; horizon_r[3] = 8192;
        acc_x = 0; acc_y = 0;
        error_count = 0; pairs_sent = 0; forces_seen = 0;
        burst_left = 0; bursty = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults();
        test_zero_radius();
        test_horizon_count();
        test_extremes();
        test_saturation();
        test_random_phases();

        settle();
        $display("covered %0d peer transfers and %0d force transfers over %0s",
                 pairs_sent, forces_seen, "directed, clamp and random register sets");
        if (error_count == 0) begin
            $display("PASS predictive_repulsion_accumulator");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL predictive_repulsion_accumulator");
        end
        $finish;
    end

endmodule
`default_nettype wire
